@@ rtl/agpm_pkg.sv @@
// ----------------------------------------------------------------------------
// agpm_pkg
// Shared types, constants and the microcode store of the gain product mixer.
// ----------------------------------------------------------------------------
package agpm_pkg;

  localparam int unsigned PC_W = 3;

  localparam logic [31:0] GAIN_RESET    = 32'h8000_0000;
  localparam logic [31:0] CEIL_RESET    = 32'h8000_0000;
  localparam logic [4:0]  SHIFT_RESET   = 5'd20;
  localparam logic [31:0] DIV_REM_INIT  = 32'h4000_0000;
  localparam logic [4:0]  DIV_LAST_BIT  = 5'd31;

  localparam logic REG_SCALE_CEILING = 1'b0;
  localparam logic REG_GROWTH_SHIFT  = 1'b1;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MUL_P,
    OP_MUL_PG,
    OP_TEST,
    OP_DIV_STEP,
    OP_MUL_Q,
    OP_EMIT,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_NOT_OVER,
    COND_CNT_NZ,
    COND_OUT_BUSY,
    COND_ALWAYS
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic over;
    logic cnt_nz;
    logic out_busy;
  } flags_t;

  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      3'd0:    w = '{op: OP_IDLE,     cond: COND_NO_INPUT, target: 3'd0};
      3'd1:    w = '{op: OP_MUL_P,    cond: COND_NEVER,    target: 3'd0};
      3'd2:    w = '{op: OP_MUL_PG,   cond: COND_NEVER,    target: 3'd0};
      3'd3:    w = '{op: OP_TEST,     cond: COND_NOT_OVER, target: 3'd5};
      3'd4:    w = '{op: OP_DIV_STEP, cond: COND_CNT_NZ,   target: 3'd4};
      3'd5:    w = '{op: OP_MUL_Q,    cond: COND_NEVER,    target: 3'd0};
      3'd6:    w = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: 3'd6};
      default: w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: 3'd0};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/agpm_seq.sv @@
// ----------------------------------------------------------------------------
// agpm_seq
// Step counter and microcode store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module agpm_seq
  import agpm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  logic            take;

  assign ctrl_o = rom_word(pc_q);

  always_comb begin
    case (ctrl_o.cond)
      COND_NEVER:    take = 1'b0;
      COND_NO_INPUT: take = !flags_i.in_valid;
      COND_NOT_OVER: take = !flags_i.over;
      COND_CNT_NZ:   take = flags_i.cnt_nz;
      COND_OUT_BUSY: take = flags_i.out_busy;
      COND_ALWAYS:   take = 1'b1;
      default:       take = 1'b1;
    endcase
    pc_d = take ? ctrl_o.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ rtl/agpm_datapath.sv @@
// ----------------------------------------------------------------------------
// agpm_datapath
// Shared multiplier, restoring divider step, gain bank and output register.
// ----------------------------------------------------------------------------
module agpm_datapath
  import agpm_pkg::*;
#(
  parameter int unsigned CHANNELS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  output flags_t      flags_o,
  input  logic [31:0] ceiling_i,
  input  logic [4:0]  shift_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_first_i,
  input  logic [15:0] sample_second_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] mixed_sample_o,
  output logic        gain_cut_o
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  logic [31:0]     gain_q [CHANNELS];
  logic [CH_W-1:0] ch_q;
  logic            out_valid_q;
  logic [15:0]     ua_q, ub_q;
  logic [31:0]     p_q, g_q, rem_q;
  logic [63:0]     prod_q;
  logic [4:0]      cnt_q;
  logic            cut_q;
  logic [15:0]     mixed_q;
  logic            gcut_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_res;
  logic        accept, over, out_busy, emit;
  logic [32:0] grown, rem2, rem_sub;
  logic        ge;
  logic [17:0] v;
  logic        frac;
  logic [15:0] y;

  assign in_ready_o = (ctrl_i.op == OP_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign emit       = (ctrl_i.op == OP_EMIT) && !out_busy;
  assign over       = prod_q[63] || (prod_q[62] && (|prod_q[61:0]));

  assign flags_o = '{in_valid: in_valid_i, over: over, cnt_nz: (cnt_q != '0),
                     out_busy: out_busy};

  always_comb begin
    case (ctrl_i.op)
      OP_MUL_P: begin
        mul_a = {16'd0, ua_q};
        mul_b = {16'd0, ub_q};
      end
      OP_MUL_PG: begin
        mul_a = prod_q[31:0];
        mul_b = g_q;
      end
      default: begin
        mul_a = p_q;
        mul_b = g_q;
      end
    endcase
    mul_res = 64'(mul_a) * 64'(mul_b);
  end

  assign grown   = {1'b0, g_q} + {1'b0, g_q >> shift_i};
  assign rem2    = {rem_q, 1'b0};
  assign ge      = rem2 >= {1'b0, p_q};
  assign rem_sub = rem2 - {1'b0, p_q};

  always_comb begin
    v    = prod_q[63:46];
    frac = |prod_q[45:0];
    if (v[17:16] != 2'b00) begin
      y = 16'h7FFF;
    end else begin
      y = {~v[15], v[14:0]} + {15'd0, (!v[15] && frac)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CHANNELS; k++) begin
        gain_q[k] <= GAIN_RESET;
      end
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.op == OP_MUL_Q) begin
        gain_q[ch_q] <= g_q;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        ch_q        <= (ch_q == CH_LAST) ? '0 : ch_q + 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_IDLE: begin
        if (accept) begin
          ua_q <= sample_first_i ^ 16'h8000;
          ub_q <= sample_second_i ^ 16'h8000;
          g_q  <= gain_q[ch_q];
        end
      end
      OP_MUL_P: prod_q <= mul_res;
      OP_MUL_PG: begin
        p_q    <= prod_q[31:0];
        prod_q <= mul_res;
      end
      OP_TEST: begin
        if (over) begin
          rem_q <= DIV_REM_INIT;
          cnt_q <= DIV_LAST_BIT;
          cut_q <= 1'b1;
        end else begin
          cut_q <= 1'b0;
          if (g_q > ceiling_i) begin
            g_q <= ceiling_i;
          end else begin
            g_q <= grown[32] ? 32'hFFFF_FFFF : grown[31:0];
          end
        end
      end
      OP_DIV_STEP: begin
        rem_q <= ge ? rem_sub[31:0] : rem2[31:0];
        g_q   <= {g_q[30:0], ge};
        cnt_q <= cnt_q - 1'b1;
      end
      OP_MUL_Q: prod_q <= mul_res;
      OP_EMIT: begin
        if (emit) begin
          mixed_q <= y;
          gcut_q  <= cut_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = mixed_q;
  assign gain_cut_o     = gcut_q;

endmodule

@@ rtl/adaptive_gain_product_mixer_top.sv @@
// ----------------------------------------------------------------------------
// adaptive_gain_product_mixer_top
// Mixes sample pairs by product with an adaptive per-channel gain.
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata: sample_first, sample_second
// m_axis    out  tvalid/tready           tdata: mixed_sample; tuser: gain_cut
// cfg       in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// When the gain is cut, the reciprocal comes from a restoring divider stepping
// one quotient bit per cycle. One word is in work at a time. Reset restores
// gains to 2.0, the default registers and channel zero. A result that has not
// moved holds the sequencer at the emit step of the next word; that next word
// is still taken while the result waits.
// ----------------------------------------------------------------------------
module adaptive_gain_product_mixer_top
  import agpm_pkg::*;
#(
  parameter int unsigned CHANNELS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] sample_first, [31:16] sample_second
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] mixed_sample
  output logic        m_axis_tuser,   // [0] gain_cut
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] ceiling_q;
  logic [4:0]  shift_q;
  ctrl_t       ctrl;
  flags_t      flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceiling_q <= CEIL_RESET;
      shift_q   <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCALE_CEILING: ceiling_q <= cfg_data_i;
        REG_GROWTH_SHIFT:  shift_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  agpm_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  agpm_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .flags_o         (flags),
    .ceiling_i       (ceiling_q),
    .shift_i         (shift_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .sample_first_i  (s_axis_tdata[15:0]),
    .sample_second_i (s_axis_tdata[31:16]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .mixed_sample_o  (m_axis_tdata),
    .gain_cut_o      (m_axis_tuser)
  );

endmodule
